// ===== hw/rtl/wsfp_pkg.sv =====
// Package for the WebSocket frame parser: parser phases, header codes and
// the entry type passed from the front end to the back end. No dependencies.
`default_nettype none

package wsfp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [6:0] LEN_CODE_ZERO  = 7'd0;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [2:0] KEY_BYTES      = 3'd4;

   typedef enum logic [2:0] {
      PH_HDR0   = 3'd0,
      PH_HDR1   = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_KEY    = 3'd3,
      PH_DATA   = 3'd4
   } wsfp_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic [3:0] opcode;
      logic       masked;
      logic       has_data;
      logic       last;
   } wsfp_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wsfp_front.sv =====
// Front end of the WebSocket frame parser: header parsing state machine that
// classifies each byte and emits result entries. Depends on wsfp_pkg.
`default_nettype none

module wsfp_front #(
   parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              rx_byte,
   output      logic                    res_valid,
   output      wsfp_pkg::wsfp_entry_type res
);

   wsfp_pkg::wsfp_phase_type phase_ff, phase_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_ff, mask_in;
   logic [3:0]             lbl_ff, lbl_in;
   logic [LENGTH_BITS-1:0] pl_ff, pl_in;
   logic [31:0]            key_ff, key_in;
   logic [2:0]             kb_ff, kb_in;
   logic [1:0]             kp_ff, kp_in;

   logic [LENGTH_BITS-1:0] pl_dec;
   logic [LENGTH_BITS-1:0] pl_shift;
   logic [3:0]             lbl_dec;
   logic [2:0]             kb_dec;
   logic [6:0]             len7;
   logic [7:0]             key_byte;

   assign pl_dec   = pl_ff - LENGTH_BITS'(1);
   assign pl_shift = {pl_ff[LENGTH_BITS-9:0], rx_byte};
   assign lbl_dec  = lbl_ff - 4'd1;
   assign kb_dec   = kb_ff - 3'd1;
   assign len7     = rx_byte[6:0];

   always_comb begin
      case (kp_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      lbl_in    = lbl_ff;
      pl_in     = pl_ff;
      key_in    = key_ff;
      kb_in     = kb_ff;
      kp_in     = kp_ff;
      if (accept) begin
         case (phase_ff)
            wsfp_pkg::PH_HDR1: begin
               mask_in = rx_byte[7];
               pl_in   = '0;
               if (len7 == wsfp_pkg::LEN_CODE_EXT16) begin
                  lbl_in   = wsfp_pkg::EXT16_BYTES;
                  phase_in = wsfp_pkg::PH_EXTLEN;
               end else if (len7 == wsfp_pkg::LEN_CODE_EXT64) begin
                  lbl_in   = wsfp_pkg::EXT64_BYTES;
                  phase_in = wsfp_pkg::PH_EXTLEN;
               end else begin
                  pl_in = LENGTH_BITS'(len7);
                  if (rx_byte[7]) begin
                     kb_in    = wsfp_pkg::KEY_BYTES;
                     phase_in = wsfp_pkg::PH_KEY;
                  end else begin
                     kp_in    = 2'd0;
                     phase_in = (len7 == wsfp_pkg::LEN_CODE_ZERO) ?
                                wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_DATA;
                  end
               end
            end
            wsfp_pkg::PH_EXTLEN: begin
               pl_in  = pl_shift;
               lbl_in = lbl_dec;
               if (lbl_dec == 4'd0) begin
                  if (mask_ff) begin
                     kb_in    = wsfp_pkg::KEY_BYTES;
                     phase_in = wsfp_pkg::PH_KEY;
                  end else begin
                     kp_in    = 2'd0;
                     phase_in = (pl_shift == '0) ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_DATA;
                  end
               end
            end
            wsfp_pkg::PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               kb_in  = kb_dec;
               if (kb_dec == 3'd0) begin
                  kp_in    = 2'd0;
                  phase_in = (pl_ff == '0) ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_DATA;
               end
            end
            wsfp_pkg::PH_DATA: begin
               kp_in = kp_ff + 2'd1;
               pl_in = pl_dec;
               if (pl_dec == '0) begin
                  phase_in = wsfp_pkg::PH_HDR0;
               end
            end
            default: begin
               opcode_in = rx_byte[3:0];
               phase_in  = wsfp_pkg::PH_HDR1;
            end
         endcase
      end
   end

   always_comb begin
      res_valid    = 1'b0;
      res.data     = 8'd0;
      res.key      = 8'd0;
      res.opcode   = opcode_ff;
      res.masked   = mask_ff;
      res.has_data = 1'b0;
      res.last     = 1'b1;
      if (accept) begin
         case (phase_ff)
            wsfp_pkg::PH_HDR1: begin
               res.masked = rx_byte[7];
               res_valid  = !rx_byte[7] && (len7 == wsfp_pkg::LEN_CODE_ZERO);
            end
            wsfp_pkg::PH_EXTLEN: begin
               res_valid = (lbl_dec == 4'd0) && !mask_ff && (pl_shift == '0);
            end
            wsfp_pkg::PH_KEY: begin
               res_valid = (kb_dec == 3'd0) && (pl_ff == '0);
            end
            wsfp_pkg::PH_DATA: begin
               res_valid    = 1'b1;
               res.data     = rx_byte;
               res.key      = mask_ff ? key_byte : 8'd0;
               res.has_data = 1'b1;
               res.last     = (pl_dec == '0);
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsfp_pkg::PH_HDR0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         lbl_ff    <= 4'd0;
         pl_ff     <= '0;
         key_ff    <= 32'd0;
         kb_ff     <= 3'd0;
         kp_ff     <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         lbl_ff    <= lbl_in;
         pl_ff     <= pl_in;
         key_ff    <= key_in;
         kb_ff     <= kb_in;
         kp_ff     <= kp_in;
      end
   end

   a_res_needs_accept: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> accept)
      else $error("result entry produced without an accepted byte");

   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.has_data |-> res.last && res.data == 8'd0 && res.key == 8'd0)
      else $error("empty-frame marker is malformed");

   a_data_emits: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == wsfp_pkg::PH_DATA |-> res_valid && res.has_data)
      else $error("payload byte did not produce a result");

   a_unmasked_key: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.masked |-> res.key == 8'd0)
      else $error("key applied to an unmasked frame");

endmodule

`default_nettype wire

// ===== hw/rtl/wsfp_queue.sv =====
// Short register queue between the parser front end and the output back end.
// Depends on wsfp_pkg for the entry type.
`default_nettype none

module wsfp_queue #(
   parameter int DEPTH = wsfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire wsfp_pkg::wsfp_entry_type push_entry,
   output      logic                     full,
   input  wire logic                     pop,
   output      wsfp_pkg::wsfp_entry_type head,
   output      logic                     empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   wsfp_pkg::wsfp_entry_type entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count lost a write");

endmodule

`default_nettype wire

// ===== hw/rtl/wsfp_back.sv =====
// Back end of the WebSocket frame parser: unmasks queued entries into the
// output register and hands results out. Depends on wsfp_pkg.
`default_nettype none

module wsfp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_empty,
   input  wire wsfp_pkg::wsfp_entry_type q_head,
   output      logic                     q_pop,
   output      logic [7:0]               payload_byte,
   output      logic [3:0]               frame_opcode,
   output      logic                     was_masked,
   output      logic                     has_data,
   output      logic                     last_of_frame,
   output      logic                     out_empty,
   input  wire logic                     out_pop
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic [3:0] opcode_ff;
   logic       masked_ff;
   logic       has_ff;
   logic       last_ff;
   logic       take;

   assign take     = out_pop && valid_ff;
   assign q_pop    = !q_empty && (!valid_ff || take);
   assign valid_in = q_pop || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff   <= q_head.data ^ q_head.key;
         opcode_ff <= q_head.opcode;
         masked_ff <= q_head.masked;
         has_ff    <= q_head.has_data;
         last_ff   <= q_head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign payload_byte  = data_ff;
   assign frame_opcode  = opcode_ff;
   assign was_masked    = masked_ff;
   assign has_data      = has_ff;
   assign last_of_frame = last_ff;
   assign out_empty     = !valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_parser.sv =====
// Top level of the WebSocket frame parser: front end, entry queue and back end.
// Depends on wsfp_pkg, wsfp_front, wsfp_queue and wsfp_back.
//
//   Channel   Handshake         Payload
//   request   req_push/req_full req_rx_byte[7:0]
//   result    rsp_pop/rsp_empty rsp_payload_byte, rsp_frame_opcode, rsp_was_masked,
//                               rsp_has_data, rsp_last_of_frame
//
// One byte is accepted per cycle, stalling only when the entry queue is full;
// header bytes produce no result, except the byte that completes the header of an
// empty frame, which produces the marker. A result is written into the entry queue
// and then into the output register before it reaches the result ports. The output
// register drains the queue at one entry per cycle while results are popped.
// Reset returns the parser to the first header byte and empties the queue.
`default_nettype none

module websocket_frame_parser #(
   parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = wsfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output      logic       req_full,
   input  wire logic [7:0] req_rx_byte,
   output      logic [7:0] rsp_payload_byte,
   output      logic [3:0] rsp_frame_opcode,
   output      logic       rsp_was_masked,
   output      logic       rsp_has_data,
   output      logic       rsp_last_of_frame,
   output      logic       rsp_empty,
   input  wire logic       rsp_pop
);

   logic                     accept;
   logic                     res_valid;
   wsfp_pkg::wsfp_entry_type res;
   wsfp_pkg::wsfp_entry_type q_head;
   logic                     q_empty;
   logic                     q_pop;

   assign accept = req_push && !req_full;

   wsfp_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .res_valid(res_valid),
      .res(res)
   );

   wsfp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(res_valid),
      .push_entry(res),
      .full(req_full),
      .pop(q_pop),
      .head(q_head),
      .empty(q_empty)
   );

   wsfp_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .payload_byte(rsp_payload_byte),
      .frame_opcode(rsp_frame_opcode),
      .was_masked(rsp_was_masked),
      .has_data(rsp_has_data),
      .last_of_frame(rsp_last_of_frame),
      .out_empty(rsp_empty),
      .out_pop(rsp_pop)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for websocket_frame_parser: streams frame bytes, predicts every
// result, masked or not, and checks each one on the result queue interface.
// Depends on wsfp_pkg and the websocket_frame_parser RTL.

module testbench;

   localparam int LEN_BITS   = wsfp_pkg::LENGTH_BITS_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int STREAM_LEN = 520;
   localparam logic [63:0] LEN_MASK =
      (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);

   typedef enum int {
      FORM_SHORT,
      FORM_EXT16,
      FORM_EXT64
   } len_form_type;

   typedef struct {
      logic [7:0] value;
      bit         drain_first;
   } rx_item_type;

   typedef struct {
      logic [7:0] payload;
      logic [3:0] opcode;
      logic       masked;
      logic       has_data;
      logic       last;
   } frame_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_rx_byte = 8'h00;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_was_masked;
   logic       rsp_has_data;
   logic       rsp_last_of_frame;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;

   rx_item_type      rx_stream[$];
   frame_result_type expected_results[$];

   wsfp_pkg::wsfp_phase_type hdr_phase;
   logic [3:0]     cur_opcode;
   logic           cur_masked;
   logic [3:0]     ext_bytes_left;
   logic [63:0]    bytes_to_go;
   logic [31:0]    unmask_key;
   logic [2:0]     key_bytes_left;
   logic [1:0]     key_idx;

   int  mismatch_count = 0;
   int  results_seen = 0;
   int  markers_seen = 0;
   int  bytes_accepted = 0;
   int  frames_queued = 0;
   int  drain_pauses = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  pop_stall = 0;
   bit  send_calm = 1'b0;
   bit  pop_calm = 1'b0;

   websocket_frame_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_opcode  (rsp_frame_opcode),
      .rsp_was_masked    (rsp_was_masked),
      .rsp_has_data      (rsp_has_data),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
      end
   endtask

   function automatic void expect_result(logic [7:0] payload, logic has_data, logic last);
      frame_result_type r;
      r.payload  = payload;
      r.opcode   = cur_opcode;
      r.masked   = cur_masked;
      r.has_data = has_data;
      r.last     = last;
      expected_results = {expected_results, r};
   endfunction

   function automatic void finish_length();
      if (cur_masked) begin
         key_bytes_left = wsfp_pkg::KEY_BYTES;
         hdr_phase      = wsfp_pkg::PH_KEY;
      end else begin
         key_idx = 2'd0;
         if (bytes_to_go == 64'd0) begin
            hdr_phase = wsfp_pkg::PH_HDR0;
            expect_result(8'h00, 1'b0, 1'b1);
         end else begin
            hdr_phase = wsfp_pkg::PH_DATA;
         end
      end
   endfunction

   // Advances the parser state by one accepted byte and queues any result.
   function automatic void parse_rx_byte(logic [7:0] b);
      logic [7:0] k;
      case (hdr_phase)
         wsfp_pkg::PH_HDR1: begin
            cur_masked  = b[7];
            bytes_to_go = 64'd0;
            if (b[6:0] == wsfp_pkg::LEN_CODE_EXT16) begin
               ext_bytes_left = wsfp_pkg::EXT16_BYTES;
               hdr_phase      = wsfp_pkg::PH_EXTLEN;
            end else if (b[6:0] == wsfp_pkg::LEN_CODE_EXT64) begin
               ext_bytes_left = wsfp_pkg::EXT64_BYTES;
               hdr_phase      = wsfp_pkg::PH_EXTLEN;
            end else begin
               bytes_to_go = {57'd0, b[6:0]} & LEN_MASK;
               finish_length();
            end
         end
         wsfp_pkg::PH_EXTLEN: begin
            bytes_to_go    = ((bytes_to_go << 8) | {56'd0, b}) & LEN_MASK;
            ext_bytes_left = ext_bytes_left - 4'd1;
            if (ext_bytes_left == 4'd0) begin
               finish_length();
            end
         end
         wsfp_pkg::PH_KEY: begin
            unmask_key     = {unmask_key[23:0], b};
            key_bytes_left = key_bytes_left - 3'd1;
            if (key_bytes_left == 3'd0) begin
               key_idx = 2'd0;
               if (bytes_to_go == 64'd0) begin
                  hdr_phase = wsfp_pkg::PH_HDR0;
                  expect_result(8'h00, 1'b0, 1'b1);
               end else begin
                  hdr_phase = wsfp_pkg::PH_DATA;
               end
            end
         end
         wsfp_pkg::PH_DATA: begin
            k           = cur_masked ? unmask_key[31 - 8 * key_idx -: 8] : 8'h00;
            key_idx     = key_idx + 2'd1;
            bytes_to_go = (bytes_to_go - 64'd1) & LEN_MASK;
            expect_result(b ^ k, 1'b1, bytes_to_go == 64'd0);
            if (bytes_to_go == 64'd0) begin
               hdr_phase = wsfp_pkg::PH_HDR0;
            end
         end
         default: begin
            cur_opcode = b[3:0];
            hdr_phase  = wsfp_pkg::PH_HDR1;
         end
      endcase
   endfunction

   function automatic void queue_byte(logic [7:0] value, bit drain_first);
      rx_item_type item;
      item.value       = value;
      item.drain_first = drain_first;
      rx_stream = {rx_stream, item};
   endfunction

   // Queues one frame; only the first 'keep' payload bytes are sent.
   function automatic void add_frame(logic [7:0] first_byte, bit masked, logic [63:0] len,
                                     len_form_type form, logic [31:0] key, bit extreme,
                                     bit drain_first, int keep);
      longint count;
      logic [7:0] b;
      queue_byte(first_byte, drain_first);
      case (form)
         FORM_SHORT: begin
            queue_byte({masked, len[6:0]}, 1'b0);
         end
         FORM_EXT16: begin
            queue_byte({masked, wsfp_pkg::LEN_CODE_EXT16}, 1'b0);
            queue_byte(len[15:8], 1'b0);
            queue_byte(len[7:0], 1'b0);
         end
         default: begin
            queue_byte({masked, wsfp_pkg::LEN_CODE_EXT64}, 1'b0);
            for (int i = 7; i >= 0; i--) begin
               queue_byte(len[8 * i +: 8], 1'b0);
            end
         end
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) begin
            queue_byte(key[8 * i +: 8], 1'b0);
         end
      end
      count = (len < 64'(keep)) ? longint'(len) : longint'(keep);
      for (longint i = 0; i < count; i++) begin
         if (extreme) begin
            b = i[0] ? 8'hFF : 8'h00;
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         queue_byte(b, 1'b0);
      end
      frames_queued++;
   endfunction

   function automatic int draw_idle(bit calm);
      return calm ? 0 : int'($urandom_range(0, 15));
   endfunction

   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            parse_rx_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (!(req_push && req_full)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (rx_stream.size() > 0 &&
                         !(rx_stream[0].drain_first && expected_results.size() != 0)) begin
               if (rx_stream[0].drain_first) begin
                  drain_pauses++;
               end
               req_rx_byte <= rx_stream[0].value;
               req_push    <= 1'b1;
               void'(rx_stream.pop_front());
               if ($urandom_range(0, 39) == 0) begin
                  send_calm = !send_calm;
               end
               send_gap = draw_idle(send_calm);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      frame_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_stall = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want = expected_results.pop_front();
               check_field("payload_byte", rsp_payload_byte, want.payload);
               check_field("frame_opcode", {4'd0, rsp_frame_opcode}, {4'd0, want.opcode});
               check_field("was_masked", {7'd0, rsp_was_masked}, {7'd0, want.masked});
               check_field("has_data", {7'd0, rsp_has_data}, {7'd0, want.has_data});
               check_field("last_of_frame", {7'd0, rsp_last_of_frame}, {7'd0, want.last});
            end
            if (!rsp_has_data) begin
               markers_seen++;
            end
            results_seen++;
            if ($urandom_range(0, 39) == 0) begin
               pop_calm = !pop_calm;
            end
            pop_stall = draw_idle(pop_calm);
         end
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [63:0]  len;
      len_form_type form;
      int           pick;
      int           frame_no;

      hdr_phase      = wsfp_pkg::PH_HDR0;
      cur_opcode     = 4'd0;
      cur_masked     = 1'b0;
      ext_bytes_left = 4'd0;
      bytes_to_go    = 64'd0;
      unmask_key     = 32'd0;
      key_bytes_left = 3'd0;
      key_idx        = 2'd0;

      // Empty frames with and without a key; one byte with FIN and RSV1-3 set;
      // masked two bytes; masked three bytes with a non-minimal 16-bit length.
      add_frame(8'h81, 1'b0, 64'd0, FORM_SHORT, 32'h0, 1'b0, 1'b0, 1 << 30);
      add_frame(8'h0F, 1'b1, 64'd0, FORM_EXT16, 32'hFFFF_FFFF, 1'b0, 1'b0, 1 << 30);
      add_frame(8'hF0, 1'b0, 64'd1, FORM_SHORT, 32'h0, 1'b1, 1'b0, 1 << 30);
      add_frame(8'h8A, 1'b1, 64'd2, FORM_SHORT, 32'hFF00_A55A, 1'b1, 1'b0, 1 << 30);
      add_frame(8'h02, 1'b1, 64'd3, FORM_EXT16, 32'h00FF_5AA5, 1'b1, 1'b0, 1 << 30);

      frame_no = 0;
      while (rx_stream.size() < STREAM_LEN) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            len = 64'd0;
         end else if (pick < 7) begin
            len = 64'($urandom_range(1, 12));
         end else if (pick < 9) begin
            len = 64'($urandom_range(13, 40));
         end else begin
            len = 64'($urandom_range(100, 140));
         end
         pick = $urandom_range(0, 5);
         if (pick >= 4) begin
            form = FORM_EXT64;
         end else if (pick >= 2 || len > 64'd125) begin
            form = FORM_EXT16;
         end else begin
            form = FORM_SHORT;
         end
         add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len, form,
                   32'($urandom), 1'b0, (frame_no % 30) == 5, 1 << 30);
         frame_no++;
      end
      // A last frame whose 64-bit length has its top bit set; it stays open.
      add_frame(8'($urandom_range(0, 255)), 1'b1, 64'h8000_0000_0000_0000 | 64'($urandom),
                FORM_EXT64, 32'($urandom), 1'b0, 1'b0, 6);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (rx_stream.size() != 0 || req_push) begin
         @(posedge clock);
      end
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("Sent %0d frames as %0d bytes, with %0d drain pauses.",
               frames_queued, bytes_accepted, drain_pauses);
      $display("Checked %0d results, %0d of them empty-frame markers; %0d mismatches.",
               results_seen, markers_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
